// File: hdl/cts_pkg.sv
// shared types, codes and keyword tables for the token scanner
`timescale 1ns / 1ps

package cts_pkg;

  typedef enum logic [3:0] {
    ST_START  = 4'd0,
    ST_INT    = 4'd1,
    ST_DOT    = 4'd2,
    ST_REAL   = 4'd3,
    ST_ASSIGN = 4'd4,
    ST_REL    = 4'd5,
    ST_BANG   = 4'd6,
    ST_AMP    = 4'd7,
    ST_BAR    = 4'd8,
    ST_IDENT  = 4'd9,
    ST_STRING = 4'd11
  } state_e;

  typedef enum logic [4:0] {
    K_IDENT  = 5'd0,
    K_ADD    = 5'd1,
    K_MUL    = 5'd2,
    K_END    = 5'd3,
    K_INT    = 5'd4,
    K_REAL   = 5'd5,
    K_ASSIGN = 5'd6,
    K_REL    = 5'd7,
    K_AND    = 5'd8,
    K_OR     = 5'd9,
    K_NOT    = 5'd10,
    K_LPAREN = 5'd11,
    K_RPAREN = 5'd12,
    K_LBRACE = 5'd13,
    K_RBRACE = 5'd14,
    K_SEMI   = 5'd15,
    K_COMMA  = 5'd16,
    K_IF     = 5'd17,
    K_WHILE  = 5'd18,
    K_RETURN = 5'd19,
    K_ELSE   = 5'd20,
    K_TYPE   = 5'd21,
    K_EQUAL  = 5'd22,
    K_STRING = 5'd23,
    K_ERROR  = 5'd24
  } kind_e;

  localparam int KIND_W = 5;
  localparam int NUM_KW = 7;
  localparam logic [NUM_KW-1:0] KW_ALL = '1;

  // scanner control state, one token in flight
  typedef struct packed {
    state_e            st;
    logic [NUM_KW-1:0] kw;
    logic              tail;
  } ctl_t;

  localparam ctl_t CTL_RESET = '{st: ST_START, kw: KW_ALL, tail: 1'b0};

  // results of one character: count and kinds of up to two tokens
  typedef struct packed {
    logic [1:0] n;
    kind_e      k0;
    kind_e      k1;
  } res_t;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // keyword text, right aligned: first character in the highest used byte
  localparam logic [47:0] KW_TEXT [NUM_KW] = '{
    48'("if"), 48'("while"), 48'("return"), 48'("else"),
    48'("int"), 48'("float"), 48'("void")
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd2, 3'd5, 3'd6, 3'd4, 3'd3, 3'd5, 3'd4};
  localparam kind_e KW_KIND [NUM_KW] = '{
    K_IF, K_WHILE, K_RETURN, K_ELSE, K_TYPE, K_TYPE, K_TYPE
  };

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = c >= 8'h30 && c <= 8'h39;
  endfunction

  // drop keywords that cannot match character c at position pos (7 = past all)
  function automatic logic [NUM_KW-1:0] kw_feed(input logic [NUM_KW-1:0] flags,
                                                input logic [2:0] pos,
                                                input logic [7:0] c);
    logic [NUM_KW-1:0] f;
    logic [2:0]        idx;
    f = flags;
    for (int i = 0; i < NUM_KW; i++) begin
      idx = KW_LEN[i] - 3'd1 - pos;
      if (pos >= KW_LEN[i] || KW_TEXT[i][{idx, 3'b000} +: 8] != c) begin
        f[i] = 1'b0;
      end
    end
    kw_feed = f;
  endfunction

endpackage

// File: hdl/cts_scan_step.sv
// one scanner step: next state and up to two tokens for one character
`timescale 1ns / 1ps

module cts_scan_step #(
  parameter int LENGTH_BITS = 8,
  parameter int LINE_BITS   = 16
) (
  input  cts_pkg::ctl_t           ctl_in,
  input  logic [LENGTH_BITS-1:0]  len_in,
  input  logic [LINE_BITS-1:0]    line_in,
  input  logic [7:0]              char_code,
  input  logic                    end_of_input,
  output cts_pkg::ctl_t           ctl_out,
  output logic [LENGTH_BITS-1:0]  len_out,
  output logic [LINE_BITS-1:0]    line_out,
  output cts_pkg::res_t           res,
  output logic [LENGTH_BITS-1:0]  len0,
  output logic [LENGTH_BITS-1:0]  len1
);

  localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

  logic                   fl_v, dr_v, consumed, digit, letter;
  cts_pkg::kind_e         fl_k, dr_k, pend;
  logic [LENGTH_BITS-1:0] fl_l, dr_l, len_inc;
  logic [LINE_BITS-1:0]   line_inc;
  logic [2:0]             pos;
  cts_pkg::ctl_t          s;
  logic [LENGTH_BITS-1:0] ln;
  logic [LINE_BITS-1:0]   lc;

  always_comb begin
    digit    = cts_pkg::is_digit(char_code);
    letter   = cts_pkg::is_letter(char_code);
    len_inc  = (len_in == '1) ? len_in : len_in + LEN_ONE;
    line_inc = (line_in == '1) ? line_in : line_in + LINE_BITS'(1);
    pos      = (len_in < LENGTH_BITS'(7)) ? len_in[2:0] : 3'd7;

    // kind of the token pending in the current state
    pend = cts_pkg::K_ERROR;
    unique case (ctl_in.st)
      cts_pkg::ST_INT:    pend = cts_pkg::K_INT;
      cts_pkg::ST_REAL:   pend = cts_pkg::K_REAL;
      cts_pkg::ST_ASSIGN: pend = cts_pkg::K_ASSIGN;
      cts_pkg::ST_REL:    pend = cts_pkg::K_REL;
      cts_pkg::ST_BANG:   pend = cts_pkg::K_NOT;
      cts_pkg::ST_IDENT: begin
        pend = cts_pkg::K_IDENT;
        if (!ctl_in.tail) begin
          for (int i = cts_pkg::NUM_KW - 1; i >= 0; i--) begin
            if (ctl_in.kw[i] && len_in == LENGTH_BITS'(cts_pkg::KW_LEN[i])) begin
              pend = cts_pkg::KW_KIND[i];
            end
          end
        end
      end
      default: pend = cts_pkg::K_ERROR;
    endcase

    s        = ctl_in;
    ln       = len_in;
    lc       = line_in;
    fl_v     = 1'b0;
    fl_k     = pend;
    fl_l     = len_in;
    dr_v     = 1'b0;
    dr_k     = cts_pkg::K_ERROR;
    dr_l     = LEN_ONE;
    consumed = 1'b0;

    if (end_of_input) begin
      fl_v = (ctl_in.st != cts_pkg::ST_START);
      dr_v = 1'b1;
      dr_k = cts_pkg::K_END;
      s    = cts_pkg::CTL_RESET;
      ln   = '0;
      lc   = LINE_BITS'(1);
    end else begin
      if (ctl_in.st != cts_pkg::ST_START) begin
        // continue the pending token
        unique case (ctl_in.st)
          cts_pkg::ST_INT: begin
            if (digit || char_code == cts_pkg::CH_DOT) begin
              consumed = 1'b1;
              s.st     = digit ? cts_pkg::ST_INT : cts_pkg::ST_DOT;
              ln       = len_inc;
            end
          end
          cts_pkg::ST_DOT, cts_pkg::ST_REAL: begin
            if (digit) begin
              consumed = 1'b1;
              s.st     = cts_pkg::ST_REAL;
              ln       = len_inc;
            end
          end
          cts_pkg::ST_ASSIGN, cts_pkg::ST_BANG, cts_pkg::ST_REL: begin
            if (char_code == cts_pkg::CH_EQ) begin
              consumed = 1'b1;
              dr_v     = 1'b1;
              dr_k     = (ctl_in.st == cts_pkg::ST_REL) ? cts_pkg::K_REL : cts_pkg::K_EQUAL;
            end
          end
          cts_pkg::ST_AMP: begin
            if (char_code == cts_pkg::CH_AMP) begin
              consumed = 1'b1;
              dr_v     = 1'b1;
              dr_k     = cts_pkg::K_AND;
            end
          end
          cts_pkg::ST_BAR: begin
            if (char_code == cts_pkg::CH_BAR) begin
              consumed = 1'b1;
              dr_v     = 1'b1;
              dr_k     = cts_pkg::K_OR;
            end
          end
          cts_pkg::ST_IDENT: begin
            if (letter || digit) begin
              consumed = 1'b1;
              s.kw     = cts_pkg::kw_feed(ctl_in.kw, pos, char_code);
              s.tail   = ctl_in.tail | digit;
              ln       = len_inc;
            end
          end
          cts_pkg::ST_STRING: begin
            consumed = 1'b1;
            if (char_code == cts_pkg::CH_QUOTE) begin
              dr_v = 1'b1;
              dr_k = cts_pkg::K_STRING;
            end else begin
              if (char_code == cts_pkg::CH_NL) begin
                lc = line_inc;
              end
              ln = len_inc;
            end
          end
          default: consumed = 1'b0;
        endcase
        if (dr_v) begin
          // two-character operator or closing quote ends the token here
          dr_l = len_inc;
          s.st = cts_pkg::ST_START;
          ln   = '0;
        end
        if (!consumed) begin
          // flush and rescan the terminating character
          fl_v = 1'b1;
          s    = cts_pkg::CTL_RESET;
          ln   = '0;
        end
      end

      if (!consumed) begin
        if (char_code == cts_pkg::CH_NL) begin
          lc = line_inc;
        end else if (letter) begin
          s.st   = cts_pkg::ST_IDENT;
          s.kw   = cts_pkg::kw_feed(cts_pkg::KW_ALL, 3'd0, char_code);
          s.tail = 1'b0;
          ln     = LEN_ONE;
        end else if (digit) begin
          s.st = cts_pkg::ST_INT;
          ln   = LEN_ONE;
        end else begin
          case (char_code) inside
            cts_pkg::CH_QUOTE: begin
              s.st = cts_pkg::ST_STRING;
              ln   = LEN_ONE;
            end
            cts_pkg::CH_EQ: begin
              s.st = cts_pkg::ST_ASSIGN;
              ln   = LEN_ONE;
            end
            cts_pkg::CH_LT, cts_pkg::CH_GT: begin
              s.st = cts_pkg::ST_REL;
              ln   = LEN_ONE;
            end
            cts_pkg::CH_BANG: begin
              s.st = cts_pkg::ST_BANG;
              ln   = LEN_ONE;
            end
            cts_pkg::CH_AMP: begin
              s.st = cts_pkg::ST_AMP;
              ln   = LEN_ONE;
            end
            cts_pkg::CH_BAR: begin
              s.st = cts_pkg::ST_BAR;
              ln   = LEN_ONE;
            end
            cts_pkg::CH_PLUS, cts_pkg::CH_MINUS: begin
              dr_v = 1'b1;
              dr_k = cts_pkg::K_ADD;
            end
            cts_pkg::CH_STAR, cts_pkg::CH_SLASH: begin
              dr_v = 1'b1;
              dr_k = cts_pkg::K_MUL;
            end
            cts_pkg::CH_DOLLAR: begin
              dr_v = 1'b1;
              dr_k = cts_pkg::K_END;
            end
            cts_pkg::CH_DOT: begin
              dr_v = 1'b1;
              dr_k = cts_pkg::K_ERROR;
            end
            cts_pkg::CH_LPAREN: begin
              dr_v = 1'b1;
              dr_k = cts_pkg::K_LPAREN;
            end
            cts_pkg::CH_RPAREN: begin
              dr_v = 1'b1;
              dr_k = cts_pkg::K_RPAREN;
            end
            cts_pkg::CH_LBRACE: begin
              dr_v = 1'b1;
              dr_k = cts_pkg::K_LBRACE;
            end
            cts_pkg::CH_RBRACE: begin
              dr_v = 1'b1;
              dr_k = cts_pkg::K_RBRACE;
            end
            cts_pkg::CH_SEMI: begin
              dr_v = 1'b1;
              dr_k = cts_pkg::K_SEMI;
            end
            cts_pkg::CH_COMMA: begin
              dr_v = 1'b1;
              dr_k = cts_pkg::K_COMMA;
            end
            default: ;
          endcase
          if (dr_v) begin
            // single-character token from the start state
            dr_l = LEN_ONE;
            s.st = cts_pkg::ST_START;
            ln   = '0;
          end
        end
      end
    end

    ctl_out  = s;
    len_out  = ln;
    line_out = lc;
    res.n    = {1'b0, fl_v} + {1'b0, dr_v};
    res.k0   = fl_v ? fl_k : dr_k;
    res.k1   = dr_k;
    len0     = fl_v ? fl_l : dr_l;
    len1     = dr_l;
  end

endmodule

// File: hdl/cts_tok_fifo.sv
// four-entry token queue, up to two tokens written per cycle
`timescale 1ns / 1ps

module cts_tok_fifo #(
  parameter int W = 30
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [1:0]   push_n,
  input  logic [W-1:0] push0,
  input  logic [W-1:0] push1,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         head_valid,
  output logic         room
);

  logic [W-1:0] mem [4];
  logic [1:0]   wr_ptr, rd_ptr;
  logic [2:0]   count;
  logic         do_pop;

  assign do_pop     = pop && head_valid;
  assign head       = mem[rd_ptr];
  assign head_valid = (count != 3'd0);
  // space for a full pair of tokens
  assign room       = (count <= 3'd2);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      rd_ptr <= rd_ptr + {1'b0, do_pop};
      count  <= count + {1'b0, push_n} - {2'b00, do_pop};
    end
  end

endmodule

// File: hdl/c_like_token_scanner_unit.sv
// top level of the character-stream token scanner
// usage:
//   s_* channel takes one source byte per beat: s_tdata[7:0] is the character,
//   s_tuser flags end of input (the character is then ignored, any pending
//   token is flushed and an end token follows).
//   m_* channel gives one token per beat; m_tlast marks the last token caused
//   by one input beat. A character yields zero, one or two tokens.
// path: a character is held in the input register, is scanned and its tokens
//   enter a four-entry token queue, whose head drives m_*.
// throughput: one character per cycle while the queue holds two tokens or
//   fewer; a character that yields two tokens takes two output beats, so a
//   run of such characters drains at one token per cycle with m_tready high.
// reset: scanner at the start state, line count one, queue empty.
// stall: with m_tready low the queue fills and s_tready drops once an input
//   beat is held with no room for its tokens; nothing is lost.
`timescale 1ns / 1ps

module c_like_token_scanner_unit #(
  parameter int LENGTH_BITS = 8,
  parameter int LINE_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // char_code
  input  logic                  s_tuser,   // end_of_input
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // token_kind, lexeme_length, line_number, zero fill
  output logic [((cts_pkg::KIND_W + LENGTH_BITS + LINE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
  output logic                  m_tlast    // last_of_run
);

  localparam int OUT_W   = cts_pkg::KIND_W + LENGTH_BITS + LINE_BITS;
  localparam int TDATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int TOK_W   = OUT_W + 1;

  logic                   in_valid, in_eoi;
  logic [7:0]             in_char;
  cts_pkg::ctl_t          ctl, ctl_next;
  logic [LENGTH_BITS-1:0] tok_len, tok_len_next, len0, len1;
  logic [LINE_BITS-1:0]   line_cnt, line_cnt_next;
  cts_pkg::res_t          res;
  logic                   room, proc;
  logic [1:0]             push_n;
  logic [TOK_W-1:0]       push0, push1, head;

  assign proc     = in_valid && room;
  assign s_tready = !in_valid || room;
  assign push_n   = proc ? res.n : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_eoi  <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl      <= cts_pkg::CTL_RESET;
      tok_len  <= '0;
      line_cnt <= LINE_BITS'(1);
    end else if (proc) begin
      ctl      <= ctl_next;
      tok_len  <= tok_len_next;
      line_cnt <= line_cnt_next;
    end
  end

  cts_scan_step #(
    .LENGTH_BITS (LENGTH_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_step (
    .ctl_in       (ctl),
    .len_in       (tok_len),
    .line_in      (line_cnt),
    .char_code    (in_char),
    .end_of_input (in_eoi),
    .ctl_out      (ctl_next),
    .len_out      (tok_len_next),
    .line_out     (line_cnt_next),
    .res          (res),
    .len0         (len0),
    .len1         (len1)
  );

  // token word: last flag on top, then line, length, kind
  assign push0 = {(res.n == 2'd1), line_cnt, len0, res.k0};
  assign push1 = {1'b1, line_cnt, len1, res.k1};

  cts_tok_fifo #(
    .W (TOK_W)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_n     (push_n),
    .push0      (push0),
    .push1      (push1),
    .pop        (m_tready),
    .head       (head),
    .head_valid (m_tvalid),
    .room       (room)
  );

  assign m_tdata = TDATA_W'(head[OUT_W-1:0]);
  assign m_tlast = head[TOK_W-1];

  // end of input always closes with an end token as the last result
  a_eoi_end: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_eoi |->
      (res.n == 2'd1 && res.k0 == cts_pkg::K_END) ||
      (res.n == 2'd2 && res.k1 == cts_pkg::K_END))
    else $error("end of input without closing end token");

  // end of input returns the scanner to its reset state
  a_eoi_reset: assert property (@(posedge clk) disable iff (rst)
    proc && in_eoi |=> ctl.st == cts_pkg::ST_START && line_cnt == LINE_BITS'(1)
      && tok_len == '0)
    else $error("scanner not reset after end of input");

  // line count starts at one and never wraps to zero
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    line_cnt != '0)
    else $error("line count reached zero");

  // a character is only scanned with room for two tokens in the queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_n != 2'd0 |-> room)
    else $error("token pushed without queue room");

endmodule

// File: sim/tb_c_like_token_scanner_unit.sv
// self-checking testbench for the character-stream token scanner
`timescale 1ns / 1ps

module tb_c_like_token_scanner_unit;

  localparam int unsigned LEN_MAX     = 255;
  localparam int unsigned LINE_MAX    = 65535;
  localparam int          STUCK_LIMIT = 1000;
  localparam int          CALM_TAIL   = 300;
  localparam int          RANDOM_BEATS = 850;
  localparam logic [7:0]  CH_SPACE    = 8'h20;
  localparam logic [7:0]  CH_TAB      = 8'h09;

  typedef struct packed {
    cts_pkg::kind_e kind;
    logic [7:0]     n_chars;
    logic [15:0]    line_no;
    logic           last;
  } token_t;

  typedef struct {
    logic [7:0] ch;
    bit         eoi;
    bit         drain;
  } beat_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // char_code
  logic        s_tuser = 1'b0;    // end_of_input
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // token_kind, lexeme_length, line_number, zero fill
  logic        m_tlast;           // last_of_run

  // stimulus and checking state
  beat_t  src_q [$];
  token_t tokens_due [$];
  beat_t  next_beat;
  token_t want;
  int     beats_total = 0;
  int     beats_in = 0;
  int     fails = 0;
  int     src_gap = 0;
  int     sink_gap = 0;
  int     src_pct = 20;
  int     sink_pct = 20;
  int     idle_run;
  bit     draining = 1'b0;
  bit     nothing_due = 1'b1;
  bit     calm = 1'b0;

  // scanner shadow
  cts_pkg::state_e scan_st;
  logic [6:0]      kw_live;
  int unsigned     lex_len;
  int unsigned     cur_line;
  bit              digit_tail;
  token_t          step_tok [2];
  int              step_n;

  string word_text [7] = '{"if", "while", "return", "else", "int", "float", "void"};
  cts_pkg::kind_e word_kind [7] = '{cts_pkg::K_IF, cts_pkg::K_WHILE, cts_pkg::K_RETURN,
                                    cts_pkg::K_ELSE, cts_pkg::K_TYPE, cts_pkg::K_TYPE,
                                    cts_pkg::K_TYPE};
  string op_text [24] = '{"+", "-", "*", "/", "=", "==", "!", "!=", "<", "<=", ">", ">=",
                          "&&", "||", "&", "|", "(", ")", "{", "}", ";", ",", ".", "$"};

  c_like_token_scanner_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  function automatic bit letter_ch(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic bit digit_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void reset_scanner();
    scan_st    = cts_pkg::ST_START;
    kw_live    = '1;
    lex_len    = 0;
    cur_line   = 1;
    digit_tail = 1'b0;
  endfunction

  function automatic void lengthen();
    if (lex_len < LEN_MAX) lex_len++;
  endfunction

  function automatic void new_line();
    if (cur_line < LINE_MAX) cur_line++;
  endfunction

  function automatic void push_token(cts_pkg::kind_e k, int unsigned n);
    token_t t;
    if (step_n >= 2) return;
    t.kind    = k;
    t.n_chars = (n > LEN_MAX) ? 8'(LEN_MAX) : 8'(n);
    t.line_no = 16'(cur_line);
    t.last    = 1'b0;
    step_tok[step_n] = t;
    step_n++;
  endfunction

  function automatic void match_keywords(logic [7:0] c);
    for (int i = 0; i < 7; i++) begin
      if (lex_len >= word_text[i].len() || 8'(word_text[i][lex_len]) != c) kw_live[i] = 1'b0;
    end
  endfunction

  function automatic void step_to(cts_pkg::state_e st, logic [7:0] c);
    if (st == cts_pkg::ST_IDENT && scan_st != cts_pkg::ST_IDENT) begin
      kw_live    = '1;
      digit_tail = 1'b0;
      lex_len    = 0;
    end
    if (scan_st == cts_pkg::ST_START) lex_len = 0;
    if (st == cts_pkg::ST_IDENT) begin
      match_keywords(c);
      if (digit_ch(c)) digit_tail = 1'b1;
    end
    scan_st = st;
    lengthen();
  endfunction

  function automatic void close_single(cts_pkg::kind_e k);
    int unsigned n;
    n = (scan_st == cts_pkg::ST_START) ? 1 : lex_len + 1;
    push_token(k, n);
    scan_st = cts_pkg::ST_START;
    lex_len = 0;
  endfunction

  function automatic cts_pkg::kind_e held_kind();
    case (scan_st)
      cts_pkg::ST_INT:    return cts_pkg::K_INT;
      cts_pkg::ST_REAL:   return cts_pkg::K_REAL;
      cts_pkg::ST_ASSIGN: return cts_pkg::K_ASSIGN;
      cts_pkg::ST_REL:    return cts_pkg::K_REL;
      cts_pkg::ST_BANG:   return cts_pkg::K_NOT;
      cts_pkg::ST_IDENT: begin
        // a digit anywhere in the word rules out a keyword
        if (!digit_tail) begin
          for (int i = 0; i < 7; i++) begin
            if (kw_live[i] && lex_len == word_text[i].len()) return word_kind[i];
          end
        end
        return cts_pkg::K_IDENT;
      end
      default:   return cts_pkg::K_ERROR;
    endcase
  endfunction

  function automatic void flush_held();
    if (scan_st == cts_pkg::ST_START) return;
    push_token(held_kind(), lex_len);
    scan_st    = cts_pkg::ST_START;
    lex_len    = 0;
    kw_live    = '1;
    digit_tail = 1'b0;
  endfunction

  function automatic void start_char(logic [7:0] c);
    if (c == cts_pkg::CH_NL) begin
      new_line();
    end else if (letter_ch(c)) begin
      step_to(cts_pkg::ST_IDENT, c);
    end else if (digit_ch(c)) begin
      step_to(cts_pkg::ST_INT, c);
    end else begin
      case (c)
        cts_pkg::CH_QUOTE:                   step_to(cts_pkg::ST_STRING, c);
        cts_pkg::CH_PLUS, cts_pkg::CH_MINUS: close_single(cts_pkg::K_ADD);
        cts_pkg::CH_STAR, cts_pkg::CH_SLASH: close_single(cts_pkg::K_MUL);
        cts_pkg::CH_EQ:                      step_to(cts_pkg::ST_ASSIGN, c);
        cts_pkg::CH_DOLLAR:                  close_single(cts_pkg::K_END);
        cts_pkg::CH_DOT:                     close_single(cts_pkg::K_ERROR);
        cts_pkg::CH_LT, cts_pkg::CH_GT:      step_to(cts_pkg::ST_REL, c);
        cts_pkg::CH_BANG:                    step_to(cts_pkg::ST_BANG, c);
        cts_pkg::CH_AMP:                     step_to(cts_pkg::ST_AMP, c);
        cts_pkg::CH_BAR:                     step_to(cts_pkg::ST_BAR, c);
        cts_pkg::CH_LPAREN:                  close_single(cts_pkg::K_LPAREN);
        cts_pkg::CH_RPAREN:                  close_single(cts_pkg::K_RPAREN);
        cts_pkg::CH_LBRACE:                  close_single(cts_pkg::K_LBRACE);
        cts_pkg::CH_RBRACE:                  close_single(cts_pkg::K_RBRACE);
        cts_pkg::CH_SEMI:                    close_single(cts_pkg::K_SEMI);
        cts_pkg::CH_COMMA:                   close_single(cts_pkg::K_COMMA);
        default: ;
      endcase
    end
  endfunction

  // returns 1 when the pending token absorbs c
  function automatic bit cont_char(logic [7:0] c);
    case (scan_st)
      cts_pkg::ST_INT: begin
        if (digit_ch(c)) begin
          step_to(cts_pkg::ST_INT, c);
          return 1'b1;
        end
        if (c == cts_pkg::CH_DOT) begin
          step_to(cts_pkg::ST_DOT, c);
          return 1'b1;
        end
        return 1'b0;
      end
      cts_pkg::ST_DOT, cts_pkg::ST_REAL: begin
        if (digit_ch(c)) begin
          step_to(cts_pkg::ST_REAL, c);
          return 1'b1;
        end
        return 1'b0;
      end
      cts_pkg::ST_ASSIGN, cts_pkg::ST_BANG: begin
        if (c == cts_pkg::CH_EQ) begin
          close_single(cts_pkg::K_EQUAL);
          return 1'b1;
        end
        return 1'b0;
      end
      cts_pkg::ST_REL: begin
        if (c == cts_pkg::CH_EQ) begin
          close_single(cts_pkg::K_REL);
          return 1'b1;
        end
        return 1'b0;
      end
      cts_pkg::ST_AMP: begin
        if (c == cts_pkg::CH_AMP) begin
          close_single(cts_pkg::K_AND);
          return 1'b1;
        end
        return 1'b0;
      end
      cts_pkg::ST_BAR: begin
        if (c == cts_pkg::CH_BAR) begin
          close_single(cts_pkg::K_OR);
          return 1'b1;
        end
        return 1'b0;
      end
      cts_pkg::ST_IDENT: begin
        if (letter_ch(c) || digit_ch(c)) begin
          step_to(cts_pkg::ST_IDENT, c);
          return 1'b1;
        end
        return 1'b0;
      end
      cts_pkg::ST_STRING: begin
        if (c == cts_pkg::CH_QUOTE) begin
          close_single(cts_pkg::K_STRING);
          return 1'b1;
        end
        if (c == cts_pkg::CH_NL) new_line();
        lengthen();
        return 1'b1;
      end
      default: begin
        scan_st = cts_pkg::ST_START;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void predict_beat(logic [7:0] c, logic eoi);
    token_t t;
    step_n = 0;
    if (eoi) begin
      flush_held();
      push_token(cts_pkg::K_END, 1);
      reset_scanner();
    end else if (scan_st == cts_pkg::ST_START) begin
      start_char(c);
    end else if (!cont_char(c)) begin
      // terminator is rescanned after the pending token goes out
      flush_held();
      start_char(c);
    end
    for (int i = 0; i < step_n; i++) begin
      t = step_tok[i];
      t.last = (i == step_n - 1);
      tokens_due.push_back(t);
    end
  endfunction

  // stimulus builders
  function automatic void put_ch(logic [7:0] c);
    beat_t b;
    b.ch = c;
    b.eoi = 1'b0;
    b.drain = 1'b0;
    src_q.push_back(b);
    beats_total++;
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_ch(8'(s[i]));
  endfunction

  function automatic void put_eoi();
    beat_t b;
    b.ch = 8'($urandom_range(255, 0));
    b.eoi = 1'b1;
    b.drain = 1'b0;
    src_q.push_back(b);
    beats_total++;
  endfunction

  function automatic void put_drain();
    beat_t b;
    b.ch = 8'h00;
    b.eoi = 1'b0;
    b.drain = 1'b1;
    src_q.push_back(b);
  endfunction

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(52, 0);
    if (r < 26) return 8'("A" + r);
    if (r < 52) return 8'("a" + r - 26);
    return 8'("_");
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(9, 0));
  endfunction

  function automatic logic [7:0] rand_word_ch();
    if ($urandom_range(3, 0) == 0) return rand_digit();
    return rand_letter();
  endfunction

  function automatic logic [7:0] rand_string_ch();
    logic [7:0] c;
    c = 8'($urandom_range(255, 0));
    if (c == cts_pkg::CH_QUOTE || $urandom_range(9, 0) == 0) c = cts_pkg::CH_NL;
    return c;
  endfunction

  function automatic void put_random_token();
    int    r;
    int    n;
    string w;
    r = $urandom_range(19, 0);
    if (r < 2) begin
      put_text(word_text[$urandom_range(6, 0)]);
    end else if (r == 2) begin
      // near misses of keywords
      w = word_text[$urandom_range(6, 0)];
      if ($urandom_range(1, 0)) begin
        for (int i = 0; i < w.len() - 1; i++) put_ch(8'(w[i]));
      end else begin
        put_text(w);
        put_ch(rand_word_ch());
      end
    end else if (r < 5) begin
      put_ch(rand_letter());
      n = $urandom_range(8, 0);
      for (int i = 0; i < n; i++) put_ch(rand_word_ch());
    end else if (r == 5) begin
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++) put_ch(rand_digit());
    end else if (r < 8) begin
      n = $urandom_range(4, 1);
      for (int i = 0; i < n; i++) put_ch(rand_digit());
      put_ch(cts_pkg::CH_DOT);
      // r == 7 leaves the fraction off
      n = (r == 6) ? $urandom_range(4, 1) : 0;
      for (int i = 0; i < n; i++) put_ch(rand_digit());
    end else if (r < 13) begin
      put_text(op_text[$urandom_range(23, 0)]);
    end else if (r == 13) begin
      put_ch(cts_pkg::CH_QUOTE);
      n = $urandom_range(10, 0);
      for (int i = 0; i < n; i++) put_ch(rand_string_ch());
      if ($urandom_range(4, 0) == 0) put_eoi();
      else put_ch(cts_pkg::CH_QUOTE);
    end else if (r == 14) begin
      put_ch(8'($urandom_range(255, 0)));
    end
    case ($urandom_range(5, 0))
      2: put_ch(CH_SPACE);
      3: put_ch(cts_pkg::CH_NL);
      4: put_ch(CH_TAB);
      5: put_ch(8'($urandom_range(255, 0)));
      default: ;
    endcase
    if ($urandom_range(49, 0) == 0) put_eoi();
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap  <= 0;
      draining <= 1'b0;
      calm     <= 1'b0;
    end else begin
      calm <= (src_q.size() < CALM_TAIL);
      if (!s_tvalid || s_tready) begin
        if (src_gap != 0) begin
          s_tvalid <= 1'b0;
          src_gap  <= src_gap - 1;
        end else if (src_q.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (src_q[0].drain) begin
          s_tvalid <= 1'b0;
          if (draining && nothing_due) begin
            void'(src_q.pop_front());
            draining <= 1'b0;
          end else begin
            draining <= 1'b1;
          end
        end else if (!calm && $urandom_range(99, 0) < src_pct) begin
          s_tvalid <= 1'b0;
          src_gap  <= $urandom_range(2, 0);
        end else begin
          next_beat = src_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_beat.ch;
          s_tuser  <= next_beat.eoi;
          if ($urandom_range(127, 0) == 0) src_pct <= 20 * $urandom_range(2, 0);
        end
      end
    end
  end

  // output backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if ($urandom_range(255, 0) == 0) sink_pct <= 20 * $urandom_range(2, 0);
      if (sink_gap != 0) begin
        m_tready <= 1'b0;
        sink_gap <= sink_gap - 1;
      end else if (!calm && $urandom_range(99, 0) < sink_pct) begin
        m_tready <= 1'b0;
        sink_gap <= $urandom_range(2, 0);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_beat(s_tdata, s_tuser);
        beats_in <= beats_in + 1;
      end
      if (m_tvalid && m_tready) begin
        if (tokens_due.size() == 0) begin
          $error("unexpected token beat: kind %0d length %0d line %0d",
                 m_tdata[4:0], m_tdata[12:5], m_tdata[28:13]);
          fails++;
        end else begin
          want = tokens_due.pop_front();
          if (m_tdata[4:0] !== want.kind) begin
            $error("token_kind expected %0d got %0d", want.kind, m_tdata[4:0]);
            fails++;
          end
          if (m_tdata[12:5] !== want.n_chars) begin
            $error("lexeme_length expected %0d got %0d", want.n_chars, m_tdata[12:5]);
            fails++;
          end
          if (m_tdata[28:13] !== want.line_no) begin
            $error("line_number expected %0d got %0d", want.line_no, m_tdata[28:13]);
            fails++;
          end
          if (m_tlast !== want.last) begin
            $error("last_of_run expected %0d got %0d", want.last, m_tlast);
            fails++;
          end
        end
      end
      nothing_due <= (tokens_due.size() == 0);
    end
  end

  initial begin
    idle_run = 0;
    while (idle_run < STUCK_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_run = 0;
      else idle_run++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int mark;
    reset_scanner();

    // every keyword and broken form, and every operator but !=
    put_text("void f(int a,float b){if(a<=b&&!c)return 12.5;else ");
    put_text("while(d>=3.|e||f&g)x=y==z;}$ .q \"s\n\"");
    put_ch(8'h00);
    put_ch(8'hFF);
    put_text("<>*/+-!");
    put_eoi();
    put_text("\"open");
    put_eoi();
    put_drain();

    // saturating lexeme lengths
    put_ch("w");
    for (int i = 0; i < 259; i++) put_ch(rand_word_ch());
    put_ch(CH_SPACE);
    for (int i = 0; i < 260; i++) put_ch(rand_digit());
    put_ch(cts_pkg::CH_SEMI);
    for (int i = 0; i < 130; i++) put_ch(rand_digit());
    put_ch(cts_pkg::CH_DOT);
    for (int i = 0; i < 130; i++) put_ch(rand_digit());
    put_ch(cts_pkg::CH_QUOTE);
    for (int i = 0; i < 258; i++) put_ch(rand_string_ch());
    put_ch(cts_pkg::CH_QUOTE);
    put_eoi();
    put_drain();

    mark = beats_total;
    while (beats_total < mark + RANDOM_BEATS) begin
      put_random_token();
      if (beats_total - mark > 500 * (1 + (beats_total - mark) / 500) - 10) put_drain();
    end
    put_eoi();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (!(beats_in == beats_total && nothing_due));
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
